>>> rtl/q4dq_pkg.sv
// Shared types and constants for the q4 block dequantizer.
`timescale 1ns / 1ps
package q4dq_pkg;
	localparam logic [31:0] SIGN32   = 32'h8000_0000;
	localparam logic [31:0] QUIET32  = 32'h0040_0000;
	localparam logic [31:0] DEFNAN32 = 32'hFFC0_0000;
	localparam logic [7:0]  BIAS_SHIFT = 8'd112;

	typedef struct packed {
		logic [15:0] scale_half;
		logic [7:0]  packed_byte;
		logic        final_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] odd_value;
		logic [31:0] even_value;
	} out_pair_t;

	// widened scale split for the multiply stage
	typedef struct packed {
		logic        sign;
		logic [7:0]  expo;
		logic [22:0] frac;
		logic        is_zero;
		logic        is_inf;
		logic        is_nan;
	} wide_t;
endpackage

>>> rtl/q4dq_widen.sv
// Stage 1: binary16 scale widened to binary32 fields.
`timescale 1ns / 1ps
module q4dq_widen (
	input  logic [15:0]    scale_half,
	output q4dq_pkg::wide_t wide
);
	import q4dq_pkg::*;
	logic [4:0] e;
	logic [9:0] m;
	logic [3:0] lz;
	logic [9:0] mn;
	always_comb begin
		e = scale_half[14:10];
		m = scale_half[9:0];
		lz = 4'd0;
		for (int i = 9; i >= 0; i--) begin
			if (m[i] && lz == 4'd0) lz = 4'(10 - i);
		end
		mn = 10'(m << lz);
		wide.sign = scale_half[15];
		wide.is_zero = (e == 5'd0) && (m == 10'd0);
		wide.is_inf = (e == 5'h1F) && (m == 10'd0);
		wide.is_nan = (e == 5'h1F) && (m != 10'd0);
		if (e == 5'd0) begin
			wide.expo = 8'(8'd1 + BIAS_SHIFT - {4'd0, lz});
			wide.frac = {mn, 13'd0};
		end else if (e == 5'h1F) begin
			wide.expo = 8'hFF;
			wide.frac = {m, 13'd0};
		end else begin
			wide.expo = 8'({3'd0, e} + BIAS_SHIFT);
			wide.frac = {m, 13'd0};
		end
		if (wide.is_zero) wide.expo = 8'd0;
	end
endmodule

>>> rtl/q4dq_scale.sv
// Stages 2-3: truncating multiply of the widened scale by one signed quant.
`timescale 1ns / 1ps
module q4dq_scale (
	input  logic            clk,
	input  logic            en,
	input  q4dq_pkg::wide_t wide,
	input  logic [3:0]      quant,
	output logic [31:0]     value
);
	import q4dq_pkg::*;
	logic        neg;
	logic [3:0]  mag_n;
	logic        spec_c;
	logic [31:0] spec_val_c;
	logic [27:0] prod_s2;
	logic        sgn_s2;
	logic [7:0]  expo_s2;
	logic        spec_s2;
	logic [31:0] spec_val_s2;
	logic [2:0]  sh;
	logic [27:0] norm;
	logic [31:0] value_s3;
	always_comb begin
		neg = quant < 4'd8;
		mag_n = neg ? 4'(4'd8 - quant) : 4'(quant - 4'd8);
		spec_c = 1'b1;
		priority if (wide.is_nan) begin
			spec_val_c = {wide.sign, 8'hFF, wide.frac} | QUIET32;
		end else if (wide.is_inf) begin
			spec_val_c = (mag_n == 4'd0) ? DEFNAN32 : {wide.sign ^ neg, 8'hFF, 23'd0};
		end else if (wide.is_zero || mag_n == 4'd0) begin
			// zero factor is never negative, so the scale sign survives
			spec_val_c = {wide.sign ^ neg, 31'd0};
		end else begin
			spec_c = 1'b0;
			spec_val_c = 32'd0;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= {4'd0, 1'b1, wide.frac} * {24'd0, mag_n};
			sgn_s2 <= wide.sign ^ neg;
			expo_s2 <= wide.expo;
			spec_s2 <= spec_c;
			spec_val_s2 <= spec_val_c;
		end
	end
	always_comb begin
		priority if (prod_s2[27]) sh = 3'd4;
		else if (prod_s2[26]) sh = 3'd3;
		else if (prod_s2[25]) sh = 3'd2;
		else if (prod_s2[24]) sh = 3'd1;
		else sh = 3'd0;
		norm = prod_s2 >> sh;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			value_s3 <= spec_s2 ? spec_val_s2
				: {sgn_s2, 8'(expo_s2 + {5'd0, sh}), norm[22:0]};
		end
	end
	assign value = value_s3;
endmodule

>>> rtl/q4_block_dequantizer.sv
// Top level: q4_0 dequantizer, three-stage pipeline, one byte per cycle unless m_axis stalls.
//  channel | dir | tdata fields (low first)                 | tlast
//  s_axis  | in  | scale_half[15:0], packed_byte[23:16]       | final_byte
//  m_axis  | out | even_value[31:0], odd_value[63:32]         | final_pair
// Each byte is registered in stages 1, 2 and 3; one transfer per cycle while m_axis is not stalled.
// The pipeline advances whenever its output slot is empty or taken.
// Reset clears the stage valid bits only.
`timescale 1ns / 1ps
module q4_block_dequantizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // scale_half, packed_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // even_value, odd_value
	output logic        m_axis_tlast
);
	import q4dq_pkg::*;
	logic    adv;
	logic    v_s1, v_s2, v_s3;
	logic    l_s1, l_s2, l_s3;
	wide_t   w_s1;
	logic [7:0]  b_s1;
	wide_t   w_c;
	out_pair_t res;

	assign adv = !v_s3 || m_axis_tready;
	assign s_axis_tready = adv;

	q4dq_widen u_widen (.scale_half(s_axis_tdata[15:0]), .wide(w_c));

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= w_c;
			b_s1 <= s_axis_tdata[23:16];
			l_s1 <= s_axis_tlast;
			l_s2 <= l_s1;
			l_s3 <= l_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	q4dq_scale u_even (.clk(clk), .en(adv), .wide(w_s1), .quant(b_s1[3:0]),
		.value(res.even_value));
	q4dq_scale u_odd (.clk(clk), .en(adv), .wide(w_s1), .quant(b_s1[7:4]),
		.value(res.odd_value));

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata = {res.odd_value, res.even_value};
	assign m_axis_tlast = l_s3;

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready ##1 s_axis_tready ##1 s_axis_tready |=> m_axis_tvalid)
		else $error("transfer lost in pipeline");
`endif
endmodule
